>>> design/smm_pkg.sv
package smm_pkg;

  typedef enum logic [1:0] {
    MODE_WR_A = 2'd0,
    MODE_WR_B = 2'd1,
    MODE_MAT  = 2'd2,
    MODE_VEC  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ISSUE = 3'b010,
    S_WAIT  = 3'b100
  } state_t;

  localparam int ELEM_W = 32;
  localparam int DIM_W  = 3;
  localparam logic [DIM_W-1:0] DIM_RESET = 3'd4;

  // one term of a dot product entering the MAC
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_ctl_t;

  // finished dot product held until taken
  typedef struct packed {
    logic              vld;
    logic              clip;
    logic [ELEM_W-1:0] value;
  } mac_res_t;

endpackage

>>> design/smm_ram.sv
module smm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/smm_mac.sv
module smm_mac #(
  parameter int MAX_DIM   = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  smm_pkg::mac_ctl_t             ctl,
  input  logic [smm_pkg::ELEM_W-1:0]    a,
  input  logic [smm_pkg::ELEM_W-1:0]    b,
  input  logic                          take,
  output smm_pkg::mac_res_t             res
);

  // exact sum of MAX_DIM full products
  localparam int PROD_W = 2 * smm_pkg::ELEM_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM);

  smm_pkg::mac_ctl_t          ctl_d;
  smm_pkg::mac_ctl_t          ctl_p;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_next;
  logic                       acc_done;
  logic signed [ACC_W-1:0]    shifted;
  logic                       fits;
  logic [smm_pkg::ELEM_W-1:0] sat_value;

  assign acc_next = (ctl_p.first ? ACC_W'(0) : acc) + ACC_W'(prod);
  assign shifted  = acc >>> FRAC_BITS;
  assign fits     = (&shifted[ACC_W-1:smm_pkg::ELEM_W-1])
                 || ~(|shifted[ACC_W-1:smm_pkg::ELEM_W-1]);

  always_comb begin
    if (fits) begin
      sat_value = shifted[smm_pkg::ELEM_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      sat_value = {1'b1, {(smm_pkg::ELEM_W-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(smm_pkg::ELEM_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_d    <= '0;
      ctl_p    <= '0;
      acc_done <= 1'b0;
      res.vld  <= 1'b0;
    end else begin
      ctl_d    <= ctl;
      ctl_p    <= ctl_d;
      acc_done <= ctl_p.vld && ctl_p.last;
      if (acc_done) begin
        res.vld   <= 1'b1;
        res.value <= sat_value;
        res.clip  <= ~fits;
      end else if (take) begin
        res.vld <= 1'b0;
      end
    end
  end

  // datapath: read data -> product -> accumulator
  always_ff @(posedge clk) begin
    if (ctl_d.vld) begin
      prod <= $signed(a) * $signed(b);
    end
    if (ctl_p.vld) begin
      acc <= acc_next;
    end
  end

endmodule

>>> design/small_matrix_multiply.sv
// Small square matrix multiplier, signed fixed point (Q16.16 by default).
// Config: cfg_valid/cfg_ready write the dimension register (used as 1 to 4, reset 4);
// write it only while the block is idle. cfg_ready is always high.
// Input items (in_valid/in_stall): mode 0/1 write one element of A/B at
// row/col, mode 2 runs A*B (dim*dim results, row-major), mode 3 runs A times
// column 0 of B (dim results). Read only elements that were written.
// Write items are accepted while the block is idle; during a run in_stall stays high.
// Each result is one dot product through a single shared multiply-accumulate
// unit: the operand reads for its terms, then RAM read data, the product
// register, the accumulator and the saturated result register, before it
// moves to the output register. The next item can be accepted in the cycle
// after the last result is loaded. The shared MAC runs one dot product at a
// time, so the next one starts only after the previous result is taken.
// Output items (out_valid/out_stall) carry out_row, out_col, product,
// clipped and last (set on the final result of the run). When the receiver
// stalls, the output register holds its item and the sequencer waits before
// starting the next dot product; nothing is dropped.
// rst (synchronous) returns the block to idle, empties the output and sets
// dimension to 4; matrix contents are not cleared.
module small_matrix_multiply #(
  parameter int MAX_DIM   = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [smm_pkg::DIM_W-1:0]         dimension,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        mode,
  input  logic [1:0]                        row,
  input  logic [1:0]                        col,
  input  logic signed [smm_pkg::ELEM_W-1:0] element,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_row,
  output logic [1:0]                        out_col,
  output logic signed [smm_pkg::ELEM_W-1:0] product,
  output logic                              clipped,
  output logic                              last
);

  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  smm_pkg::state_t            state;
  logic [smm_pkg::DIM_W-1:0]  dim_reg;
  logic [IDX_W-1:0]           nlast;
  logic [IDX_W-1:0]           run_nlast;
  logic [IDX_W-1:0]           run_clast;
  logic [IDX_W-1:0]           r;
  logic [IDX_W-1:0]           c;
  logic [IDX_W-1:0]           u;
  logic                       in_accept;
  logic                       is_run;
  logic                       row_ok;
  logic [AW-1:0]              waddr;
  logic                       we_a;
  logic                       we_b;
  logic [AW-1:0]              a_raddr;
  logic [AW-1:0]              b_raddr;
  logic [smm_pkg::ELEM_W-1:0] a_rdata;
  logic [smm_pkg::ELEM_W-1:0] b_rdata;
  smm_pkg::mac_ctl_t          ctl;
  smm_pkg::mac_res_t          res;
  logic                       res_take;
  logic                       final_dot;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != smm_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign is_run    = (mode == smm_pkg::MODE_MAT) || (mode == smm_pkg::MODE_VEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_reg <= smm_pkg::DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dim_reg <= dimension;
    end
  end

  // zero acts as one, anything above MAX_DIM as MAX_DIM
  always_comb begin
    if (dim_reg == '0) begin
      nlast = '0;
    end else if (int'(dim_reg) > MAX_DIM) begin
      nlast = IDX_W'(MAX_DIM - 1);
    end else begin
      nlast = IDX_W'(dim_reg - 3'd1);
    end
  end

  // element writes
  assign row_ok = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
  assign waddr  = AW'(int'(row) * MAX_DIM + int'(col));
  assign we_a   = in_accept && (mode == smm_pkg::MODE_WR_A) && row_ok;
  assign we_b   = in_accept && (mode == smm_pkg::MODE_WR_B) && row_ok;

  assign a_raddr = AW'(int'(r) * MAX_DIM + int'(u));
  assign b_raddr = AW'(int'(u) * MAX_DIM + int'(c));

  smm_ram #(.WIDTH(smm_pkg::ELEM_W), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr),
    .wdata (element),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  smm_ram #(.WIDTH(smm_pkg::ELEM_W), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr),
    .wdata (element),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  assign ctl.vld   = (state == smm_pkg::S_ISSUE);
  assign ctl.first = (u == '0);
  assign ctl.last  = (u == run_nlast);

  smm_mac #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .a    (a_rdata),
    .b    (b_rdata),
    .take (res_take),
    .res  (res)
  );

  assign res_take  = (state == smm_pkg::S_WAIT) && res.vld && (!out_valid || !out_stall);
  assign final_dot = (r == run_nlast) && (c == run_clast);

  // sequencer: one dot product at a time, terms walked by u
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= smm_pkg::S_IDLE;
      r         <= '0;
      c         <= '0;
      u         <= '0;
      run_nlast <= '0;
      run_clast <= '0;
    end else begin
      case (state)
        smm_pkg::S_IDLE: begin
          if (in_accept && is_run) begin
            run_nlast <= nlast;
            run_clast <= (mode == smm_pkg::MODE_MAT) ? nlast : '0;
            r         <= '0;
            c         <= '0;
            u         <= '0;
            state     <= smm_pkg::S_ISSUE;
          end
        end
        smm_pkg::S_ISSUE: begin
          if (u == run_nlast) begin
            u     <= '0;
            state <= smm_pkg::S_WAIT;
          end else begin
            u <= u + 1'b1;
          end
        end
        smm_pkg::S_WAIT: begin
          if (res_take) begin
            if (final_dot) begin
              state <= smm_pkg::S_IDLE;
            end else begin
              if (c == run_clast) begin
                c <= '0;
                r <= r + 1'b1;
              end else begin
                c <= c + 1'b1;
              end
              state <= smm_pkg::S_ISSUE;
            end
          end
        end
        default: begin
          state <= smm_pkg::S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_row <= 2'(r);
      out_col <= 2'(c);
      product <= res.value;
      clipped <= res.clip;
      last    <= final_dot;
    end
  end

  a_res_in_wait: assert property (@(posedge clk) disable iff (rst)
    res.vld |-> (state == smm_pkg::S_WAIT))
    else $error("MAC result outside wait state");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state != smm_pkg::S_IDLE) |-> (r <= run_nlast) && (c <= run_clast) && (u <= run_nlast))
    else $error("run index beyond dimension");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (we_a || we_b) |-> (state == smm_pkg::S_IDLE))
    else $error("element write during a run");

  a_issue_to_wait: assert property (@(posedge clk) disable iff (rst)
    (state == smm_pkg::S_ISSUE) && (u == run_nlast) |=> (state == smm_pkg::S_WAIT))
    else $error("last term not followed by wait");

endmodule
